@@ design/tbdrc_pkg.sv @@
// Package for the two-button debounce row cycler: shared types, constants,
// the fixed profile table and the row packing function.
// No dependencies.
package tbdrc_pkg;

    // Configuration port geometry
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;
    localparam logic        REG_IDX_DEBOUNCE_DELAY = 1'b0;

    // Field widths
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned DELAY_W = 16;
    localparam int unsigned LABEL_W = 16;
    localparam int unsigned ROW_W   = 2;
    localparam int unsigned PROF_W  = 2;
    localparam int unsigned PACK_W  = 16;

    localparam int unsigned ROW_COUNT          = 4;
    localparam int unsigned MAX_SENSORS        = 8;
    localparam int unsigned SENSOR_COUNT_DEF   = 8;

    // Reset values
    localparam logic [DELAY_W-1:0]        DELAY_RESET = 16'd50;
    localparam logic signed [LABEL_W-1:0] LABEL_RESET = 16'sd1;
    localparam logic signed [LABEL_W-1:0] LABEL_MAX   = 16'sh7FFF;
    localparam logic signed [LABEL_W-1:0] LABEL_MIN   = 16'sh8000;

    // Profile assignment table, one row per chord step
    localparam logic [PROF_W-1:0] ROW_TABLE [ROW_COUNT][MAX_SENSORS] = '{
        '{2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd3, 2'd3},
        '{2'd3, 2'd3, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2},
        '{2'd2, 2'd2, 2'd3, 2'd3, 2'd0, 2'd0, 2'd1, 2'd1},
        '{2'd1, 2'd1, 2'd2, 2'd2, 2'd3, 2'd3, 2'd0, 2'd0}
    };

    // Chord and label state as seen by the result stage
    typedef struct packed {
        logic signed [LABEL_W-1:0] label_value;
        logic                      custom_mode;
        logic [ROW_W-1:0]          row_number;
        logic                      row_changed;
    } t_chord_status;

    // One result item
    typedef struct packed {
        logic signed [LABEL_W-1:0] label_value;
        logic                      custom_mode;
        logic [ROW_W-1:0]          row_number;
        logic                      row_changed;
        logic [PACK_W-1:0]         sensor_profiles;
        logic                      stable_one;
        logic                      stable_two;
    } t_result;

    // One input item
    typedef struct packed {
        logic [TIME_W-1:0] time_ms;
        logic              pin_one_level;
        logic              pin_two_level;
    } t_sample;

    // Pack a table row, sensor k in bits 2k+1..2k, unused sensors zero
    function automatic logic [PACK_W-1:0] pack_row(input logic [ROW_W-1:0] row,
                                                   input int unsigned sensors);
        logic [PACK_W-1:0] pk;
        pk = '0;
        for (int k = 0; k < MAX_SENSORS; k++) begin
            if (k < sensors) begin
                pk[PROF_W*k +: PROF_W] = ROW_TABLE[row][k];
            end
        end
        return pk;
    endfunction

endpackage

@@ design/tbdrc_ifs.sv @@
// Stream channel interfaces for the sample input and the result output.
// Valid/ready handshake; depends on nothing else.
interface tbdrc_sample_if;
    logic        valid;
    logic        ready;
    logic [31:0] time_ms;
    logic        pin_one_level;
    logic        pin_two_level;

    modport source (output valid, output time_ms, output pin_one_level,
                    output pin_two_level, input ready);
    modport sink   (input valid, input time_ms, input pin_one_level,
                    input pin_two_level, output ready);
endinterface

interface tbdrc_result_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] label_value;
    logic               custom_mode;
    logic [1:0]         row_number;
    logic               row_changed;
    logic [15:0]        sensor_profiles;
    logic               stable_one;
    logic               stable_two;

    modport source (output valid, output label_value, output custom_mode,
                    output row_number, output row_changed, output sensor_profiles,
                    output stable_one, output stable_two, input ready);
    modport sink   (input valid, input label_value, input custom_mode,
                    input row_number, input row_changed, input sensor_profiles,
                    input stable_one, input stable_two, output ready);
endinterface

@@ design/tbdrc_debounce.sv @@
// Debounce unit for one active-low button pin.
// Uses tbdrc_pkg for widths.
module tbdrc_debounce (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic [tbdrc_pkg::TIME_W-1:0]  i_time_ms,
    input  logic                        i_pin_level,
    input  logic [tbdrc_pkg::DELAY_W-1:0] i_delay_ms,
    output logic                        o_stable
);
    import tbdrc_pkg::*;

    logic              r_last_raw;
    logic [TIME_W-1:0] r_since;
    logic              r_stable;
    logic              n_last_raw;
    logic [TIME_W-1:0] n_since;
    logic              n_stable;
    logic              raw;
    logic [TIME_W-1:0] elapsed;

    // Restart the timer on a raw change, accept the level once it held long enough
    always_comb begin
        raw        = ~i_pin_level;
        n_last_raw = raw;
        n_since    = (raw != r_last_raw) ? i_time_ms : r_since;
        elapsed    = i_time_ms - n_since;
        n_stable   = (elapsed > {{(TIME_W-DELAY_W){1'b0}}, i_delay_ms}) ? raw : r_stable;
    end

    assign o_stable = n_stable;

    // Advance the button state once per transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw <= 1'b0;
            r_since    <= '0;
            r_stable   <= 1'b0;
        end else if (i_en) begin
            r_last_raw <= n_last_raw;
            r_since    <= n_since;
            r_stable   <= n_stable;
        end
    end

endmodule

@@ design/tbdrc_chord.sv @@
// Chord edge detector, row cycler and saturating label counter.
// Uses tbdrc_pkg for widths, limits and the status struct.
module tbdrc_chord (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_stable_one,
    input  logic                     i_stable_two,
    output tbdrc_pkg::t_chord_status o_status
);
    import tbdrc_pkg::*;

    logic                      r_prior_chord;
    logic                      r_prior_one;
    logic                      r_prior_two;
    logic                      r_mode;
    logic [ROW_W-1:0]          r_row;
    logic signed [LABEL_W-1:0] r_label;
    logic                      n_prior_one;
    logic                      n_prior_two;
    logic                      n_mode;
    logic [ROW_W-1:0]          n_row;
    logic signed [LABEL_W-1:0] n_label;
    logic                      both;
    logic                      fire;
    logic                      new_one;
    logic                      new_two;

    // Fire on a rising chord, otherwise count lone new presses
    always_comb begin
        both        = i_stable_one & i_stable_two;
        fire        = both & ~r_prior_chord;
        new_one     = i_stable_one & ~r_prior_one;
        new_two     = i_stable_two & ~r_prior_two;
        n_mode      = r_mode;
        n_row       = r_row;
        n_label     = r_label;
        n_prior_one = r_prior_one;
        n_prior_two = r_prior_two;
        if (fire) begin
            n_mode = 1'b1;
            n_row  = r_mode ? r_row + 1'b1 : '0;
        end else if (!both) begin
            if (new_one && !i_stable_two) begin
                if (r_label != LABEL_MAX) begin
                    n_label = r_label + 16'sd1;
                end
            end else if (new_two && !i_stable_one) begin
                if (r_label != LABEL_MIN) begin
                    n_label = r_label - 16'sd1;
                end
            end
            n_prior_one = i_stable_one;
            n_prior_two = i_stable_two;
        end
        o_status.label_value = n_label;
        o_status.custom_mode = n_mode;
        o_status.row_number  = n_row;
        o_status.row_changed = fire;
    end

    // Commit state once per transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prior_chord <= 1'b0;
            r_prior_one   <= 1'b0;
            r_prior_two   <= 1'b0;
            r_mode        <= 1'b0;
            r_row         <= '0;
            r_label       <= LABEL_RESET;
        end else if (i_en) begin
            r_prior_chord <= both;
            r_prior_one   <= n_prior_one;
            r_prior_two   <= n_prior_two;
            r_mode        <= n_mode;
            r_row         <= n_row;
            r_label       <= n_label;
        end
    end

endmodule

@@ design/two_button_debounce_row_cycler_core.sv @@
// Top level of the two-button debounce row cycler: APB register, sample
// register, two debounce units, chord/label unit and result register.
// Depends on tbdrc_pkg, tbdrc_ifs, tbdrc_debounce and tbdrc_chord.
//
//   Channel    Dir  Handshake        Payload
//   i_sample   in   valid / ready    time_ms, pin_one_level, pin_two_level
//   o_result   out  valid / ready    label_value .. stable_two (one per sample)
//   APB        in   psel / penable   debounce_delay_ms at byte address 0
//
// One sample per cycle sustained while results are taken. A sample is first
// held in the sample register, then updates all state and loads the result
// register once that register is free; result valid rises with that load.
// Reset is synchronous; no sample is taken during the reset cycle.
// A stalled result holds; the sample register keeps filling behind it and
// then holds too, so after reset ready drops only when both stages are full.
module two_button_debounce_row_cycler_core #(
    parameter int unsigned SENSOR_COUNT = tbdrc_pkg::SENSOR_COUNT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    tbdrc_sample_if.sink                      i_sample,
    tbdrc_result_if.source                    o_result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tbdrc_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [tbdrc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [tbdrc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                              pready
);
    import tbdrc_pkg::*;

    logic                r_run;
    logic [DELAY_W-1:0]  r_delay;
    logic                r_in_valid;
    t_sample             r_in;
    logic                r_out_valid;
    t_result             r_out;
    t_result             n_out;
    logic                out_free;
    logic                advance;
    logic                take_in;
    logic                cfg_wr;
    logic                stable_one;
    logic                stable_two;
    t_chord_status       chord;

    // Configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & (paddr[2] == REG_IDX_DEBOUNCE_DELAY);
    assign prdata = (paddr[2] == REG_IDX_DEBOUNCE_DELAY)
                    ? {{(APB_DATA_W-DELAY_W){1'b0}}, r_delay} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay <= DELAY_RESET;
        end else if (cfg_wr) begin
            r_delay <= pwdata[DELAY_W-1:0];
        end
    end

    // Handshake and stage control
    assign out_free       = ~r_out_valid | o_result.ready;
    assign advance        = r_in_valid & out_free;
    assign i_sample.ready = r_run & (~r_in_valid | out_free);
    assign take_in        = i_sample.valid & i_sample.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run       <= 1'b0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_run <= 1'b1;
            if (take_in) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture the sample
    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_in.time_ms       <= i_sample.time_ms;
            r_in.pin_one_level <= i_sample.pin_one_level;
            r_in.pin_two_level <= i_sample.pin_two_level;
        end
    end

    tbdrc_debounce u_deb_one (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (advance),
        .i_time_ms   (r_in.time_ms),
        .i_pin_level (r_in.pin_one_level),
        .i_delay_ms  (r_delay),
        .o_stable    (stable_one)
    );

    tbdrc_debounce u_deb_two (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (advance),
        .i_time_ms   (r_in.time_ms),
        .i_pin_level (r_in.pin_two_level),
        .i_delay_ms  (r_delay),
        .o_stable    (stable_two)
    );

    tbdrc_chord u_chord (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (advance),
        .i_stable_one (stable_one),
        .i_stable_two (stable_two),
        .o_status     (chord)
    );

    // Assemble the result
    always_comb begin
        n_out.label_value     = chord.label_value;
        n_out.custom_mode     = chord.custom_mode;
        n_out.row_number      = chord.row_number;
        n_out.row_changed     = chord.row_changed;
        n_out.sensor_profiles = pack_row(chord.row_number, SENSOR_COUNT);
        n_out.stable_one      = stable_one;
        n_out.stable_two      = stable_two;
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.label_value     = r_out.label_value;
    assign o_result.custom_mode     = r_out.custom_mode;
    assign o_result.row_number      = r_out.row_number;
    assign o_result.row_changed     = r_out.row_changed;
    assign o_result.sensor_profiles = r_out.sensor_profiles;
    assign o_result.stable_one      = r_out.stable_one;
    assign o_result.stable_two      = r_out.stable_two;

endmodule

@@ design/tbdrc_checker.sv @@
// Port-level checks for the two-button debounce row cycler, bound to the top.
// Depends on tbdrc_pkg and two_button_debounce_row_cycler_core.
module tbdrc_checker #(
    parameter int unsigned SENSOR_COUNT = tbdrc_pkg::SENSOR_COUNT_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_label_value,
    input logic        i_custom_mode,
    input logic [1:0]  i_row_number,
    input logic        i_row_changed,
    input logic [15:0] i_sensor_profiles,
    input logic        i_stable_one,
    input logic        i_stable_two
);
    import tbdrc_pkg::*;

    // A chord edge means both buttons are debounced pressed and mode is on
    a_chord_needs_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_row_changed) |-> (i_stable_one && i_stable_two && i_custom_mode))
        else $error("row change without a full chord");

    // Profiles always follow the reported row
    a_profiles_match_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_sensor_profiles == pack_row(i_row_number, SENSOR_COUNT)))
        else $error("sensor profiles do not match row");

    // Row stays at zero until custom mode is on
    a_row_zero_before_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_custom_mode) |-> (i_row_number == '0))
        else $error("row moved before custom mode");

    // Stalled result holds
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_label_value) && $stable(i_row_number)))
        else $error("result changed while stalled");

endmodule

bind two_button_debounce_row_cycler_core tbdrc_checker #(
    .SENSOR_COUNT (SENSOR_COUNT)
) u_tbdrc_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_result.valid),
    .i_out_ready       (o_result.ready),
    .i_label_value     (o_result.label_value),
    .i_custom_mode     (o_result.custom_mode),
    .i_row_number      (o_result.row_number),
    .i_row_changed     (o_result.row_changed),
    .i_sensor_profiles (o_result.sensor_profiles),
    .i_stable_one      (o_result.stable_one),
    .i_stable_two      (o_result.stable_two)
);

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the two-button debounce row cycler core.
// Streams pin samples through the valid/ready channels and checks every result
// against an in-bench model; depends on tbdrc_pkg, tbdrc_ifs and the core.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tbdrc_pkg::*;

    localparam int unsigned SENSORS      = SENSOR_COUNT_DEF;
    localparam int unsigned DRAIN_CYCLES = 6;
    localparam int unsigned STALL_CYCLES = 60;
    localparam int unsigned END_GUARD    = 20000;
    localparam int unsigned QUEUE_DEPTH  = 8;

    // Register map: the delay register at bytes 0 to 3, bytes 4 to 7 unmapped
    localparam logic [APB_ADDR_W-1:0] DELAY_ADDR  = APB_ADDR_W'(4 * REG_IDX_DEBOUNCE_DELAY);
    localparam logic [APB_ADDR_W-1:0] UNUSED_ADDR = APB_ADDR_W'(4);

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic psel, penable, pwrite, pready;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata, prdata;

    tbdrc_sample_if smp ();
    tbdrc_result_if res ();

    two_button_debounce_row_cycler_core #(
        .SENSOR_COUNT(SENSORS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sample(smp),
        .o_result(res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Model state: raw history, debounce timers, chord and label tracking
    logic [1:0]               btn_raw_q;
    logic [TIME_W-1:0]        btn_since [2];
    logic [1:0]               btn_stable;
    logic [1:0]               btn_seen;
    logic                     chord_prev;
    logic                     mode_on;
    logic [ROW_W-1:0]         row_sel;
    logic signed [LABEL_W-1:0] label_cnt;
    logic [DELAY_W-1:0]       delay_ms;

    t_sample sample_q [$];
    t_result status_q [$];

    logic [TIME_W-1:0] t_now;
    bit   idle_on    = 1'b1;
    bit   stall_req  = 1'b0;
    logic rx_hold    = 1'b0;
    int   tx_gap     = 0;
    int   rx_gap     = 0;
    int   n_accepted = 0;
    int   n_checked  = 0;
    int   n_settings = 0;
    int   err_cnt    = 0;

    int unsigned delay_plan [6] = '{3, 20, 65535, 0, 50, 1000};
    bit          idle_plan  [6] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1};

    // Predict one result and advance the model state
    function automatic t_result debounce_and_chord(input t_sample s);
        t_result    r;
        logic [1:0] raw;
        logic       both;
        logic       fresh_one;
        logic       fresh_two;
        raw[0] = ~s.pin_one_level;
        raw[1] = ~s.pin_two_level;
        r = '0;
        // Restart the timer on a raw change, accept once the hold exceeds the delay
        for (int b = 0; b < 2; b++) begin
            if (raw[b] != btn_raw_q[b]) begin
                btn_since[b] = s.time_ms;
            end
            if ((s.time_ms - btn_since[b]) > TIME_W'(delay_ms)) begin
                btn_stable[b] = raw[b];
            end
            btn_raw_q[b] = raw[b];
        end
        both = btn_stable[0] & btn_stable[1];
        if (both && !chord_prev) begin
            // Chord edge: first one enters custom mode, later ones step the row
            if (!mode_on) begin
                mode_on = 1'b1;
                row_sel = '0;
            end else begin
                row_sel = ROW_W'((int'(row_sel) + 1) % ROW_COUNT);
            end
            r.row_changed = 1'b1;
        end else if (!both) begin
            // Lone presses move the label; press history only tracks here
            fresh_one = btn_stable[0] && !btn_seen[0];
            fresh_two = btn_stable[1] && !btn_seen[1];
            if (fresh_one && !btn_stable[1]) begin
                if (label_cnt != LABEL_MAX) label_cnt = label_cnt + 16'sd1;
            end else if (fresh_two && !btn_stable[0]) begin
                if (label_cnt != LABEL_MIN) label_cnt = label_cnt - 16'sd1;
            end
            btn_seen = btn_stable;
        end
        chord_prev = both;
        r.label_value = label_cnt;
        r.custom_mode = mode_on;
        r.row_number  = row_sel;
        for (int k = 0; k < MAX_SENSORS; k++) begin
            if (k < SENSORS) begin
                r.sensor_profiles[PROF_W*k +: PROF_W] = ROW_TABLE[row_sel][k];
            end
        end
        r.stable_one = btn_stable[0];
        r.stable_two = btn_stable[1];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
        err_cnt++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    // Sample driver: present queued samples, predict on each transfer
    always @(posedge i_clk) begin : drive_samples
        t_sample cur;
        t_sample nxt;
        if (!i_rst_n) begin
            smp.valid <= 1'b0;
        end else begin
            if (smp.valid && smp.ready) begin
                cur.time_ms       = smp.time_ms;
                cur.pin_one_level = smp.pin_one_level;
                cur.pin_two_level = smp.pin_two_level;
                status_q.push_back(debounce_and_chord(cur));
                n_accepted++;
            end
            if (!smp.valid || smp.ready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    smp.valid <= 1'b0;
                end else if (idle_on && $urandom_range(0, 5) == 0) begin
                    tx_gap = $urandom_range(0, 4);
                    smp.valid <= 1'b0;
                end else if (sample_q.size() > 0) begin
                    nxt = sample_q.pop_front();
                    smp.valid         <= 1'b1;
                    smp.time_ms       <= nxt.time_ms;
                    smp.pin_one_level <= nxt.pin_one_level;
                    smp.pin_two_level <= nxt.pin_two_level;
                end else begin
                    smp.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare each transfer with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (!i_rst_n) begin
            res.ready <= 1'b0;
        end else begin
            if (res.valid && res.ready) begin
                if (status_q.size() == 0) begin
                    report_mismatch("result with nothing expected", 32'(res.label_value), 0);
                end else begin
                    want = status_q.pop_front();
                    n_checked++;
                    check_field("label_value", 32'(res.label_value), 32'(want.label_value));
                    check_field("custom_mode", 32'(res.custom_mode), 32'(want.custom_mode));
                    check_field("row_number", 32'(res.row_number), 32'(want.row_number));
                    check_field("row_changed", 32'(res.row_changed), 32'(want.row_changed));
                    check_field("sensor_profiles", 32'(res.sensor_profiles),
                                32'(want.sensor_profiles));
                    check_field("stable_one", 32'(res.stable_one), 32'(want.stable_one));
                    check_field("stable_two", 32'(res.stable_two), 32'(want.stable_two));
                end
            end
            if (rx_hold) begin
                res.ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                res.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                rx_gap = $urandom_range(0, 4);
                res.ready <= 1'b0;
            end else begin
                res.ready <= 1'b1;
            end
        end
    end

    // Long receiver hold-off so both pipeline stages fill and input ready drops
    initial begin : long_backpressure
        wait (stall_req);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (STALL_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    initial begin : watchdog
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

    // Push one sample, throttled so the pending queue stays short
    task automatic queue_sample(input logic [TIME_W-1:0] t, input logic p1, input logic p2);
        t_sample s;
        s.time_ms       = t;
        s.pin_one_level = p1;
        s.pin_two_level = p2;
        while (sample_q.size() >= QUEUE_DEPTH) @(negedge i_clk);
        sample_q.push_back(s);
    endtask

    // Usually advance the timestamp by a step scaled to the delay, then queue
    task automatic emit(input logic p1, input logic p2);
        if ($urandom_range(0, 7) != 0) begin
            t_now = t_now + TIME_W'($urandom_range(1, (int'(delay_ms) >> 2) + 2));
        end
        queue_sample(t_now, p1, p2);
    endtask

    // Hold a level for a few samples, optionally after some contact bounce
    task automatic hold_level(input logic p1, input logic p2);
        repeat ($urandom_range(0, 2)) emit(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        repeat ($urandom_range(2, 9)) emit(p1, p2);
    endtask

    task automatic run_gestures(input int count);
        for (int g = 0; g < count; g++) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    hold_level(1'b0, 1'b1);
                    hold_level(1'b1, 1'b1);
                end
                3, 4: begin
                    hold_level(1'b1, 1'b0);
                    hold_level(1'b1, 1'b1);
                end
                5, 6: begin
                    // Chord, then release one button ahead of the other or both
                    hold_level(1'b0, 1'b0);
                    case ($urandom_range(0, 2))
                        0: hold_level(1'b0, 1'b1);
                        1: hold_level(1'b1, 1'b0);
                        default: ;
                    endcase
                    hold_level(1'b1, 1'b1);
                end
                7: hold_level(1'b1, 1'b1);
                8: repeat ($urandom_range(2, 6)) begin
                    emit(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end
                default: begin
                    // Jump anywhere or step back in time
                    if ($urandom_range(0, 1) == 1) t_now = $urandom();
                    else t_now = t_now - TIME_W'($urandom_range(1, 4000));
                    queue_sample(t_now, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end
            endcase
        end
    endtask

    // Wait until every sample is through and every result has come back
    task automatic settle();
        @(negedge i_clk);
        while (sample_q.size() != 0 || smp.valid || status_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // APB write with setup and access phases, only while the core is idle
    task automatic program_register(input logic [APB_ADDR_W-1:0] addr,
                                    input logic [APB_DATA_W-1:0] data);
        settle();
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == DELAY_ADDR) begin
            delay_ms = data[DELAY_W-1:0];
            n_settings++;
        end
    endtask

    initial begin : stimulus
        int guard;
        int presses;
        // Known levels on every input from time zero
        i_rst_n           = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        smp.valid         = 1'b0;
        smp.time_ms       = '0;
        smp.pin_one_level = 1'b1;
        smp.pin_two_level = 1'b1;
        res.ready         = 1'b0;
        // Model reset values
        btn_raw_q    = '0;
        btn_since[0] = '0;
        btn_since[1] = '0;
        btn_stable   = '0;
        btn_seen     = '0;
        chord_prev   = 1'b0;
        mode_on      = 1'b0;
        row_sel      = '0;
        label_cnt    = LABEL_RESET;
        delay_ms     = DELAY_RESET;
        t_now        = '0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset delay: 50 ms held is not enough, 51 ms is
        queue_sample(32'd10, 1'b0, 1'b1);
        queue_sample(32'd60, 1'b0, 1'b1);
        queue_sample(32'd61, 1'b0, 1'b1);
        queue_sample(32'd70, 1'b1, 1'b1);
        queue_sample(32'd200, 1'b1, 1'b1);

        // Unmapped address must leave the delay alone
        program_register(UNUSED_ADDR, 32'h0000_0007);
        program_register(DELAY_ADDR, 32'h0000_0000);

        // Lone press of button two, then the first chord
        queue_sample(32'd300, 1'b1, 1'b0);
        queue_sample(32'd301, 1'b1, 1'b0);
        queue_sample(32'd302, 1'b1, 1'b1);
        queue_sample(32'd303, 1'b1, 1'b1);
        queue_sample(32'd304, 1'b0, 1'b0);
        queue_sample(32'd305, 1'b0, 1'b0);
        queue_sample(32'd306, 1'b0, 1'b0);
        // Drop button two out of the chord: the stale press flag lets one count, then the second chord
        queue_sample(32'd307, 1'b0, 1'b1);
        queue_sample(32'd308, 1'b0, 1'b1);
        queue_sample(32'd309, 1'b0, 1'b0);
        queue_sample(32'd310, 1'b0, 1'b0);
        queue_sample(32'd311, 1'b1, 1'b1);
        queue_sample(32'd312, 1'b1, 1'b1);
        // Timestamp wrap: one millisecond across zero is accepted at zero delay
        queue_sample(32'hFFFF_FFFF, 1'b1, 1'b0);
        queue_sample(32'h0000_0000, 1'b1, 1'b0);
        queue_sample(32'h0000_0001, 1'b1, 1'b1);
        queue_sample(32'h0000_0002, 1'b1, 1'b1);

        // Full-width write keeps only the low 16 bits: maximum delay
        program_register(DELAY_ADDR, 32'hFFFF_FFFF);
        // Time stepping back looks like a huge hold and is accepted
        queue_sample(32'd1000, 1'b1, 1'b0);
        queue_sample(32'd900, 1'b1, 1'b0);
        queue_sample(32'd901, 1'b1, 1'b1);
        queue_sample(32'd500, 1'b1, 1'b1);

        // Random gestures across several delay settings
        for (int p = 0; p < 6; p++) begin
            program_register(DELAY_ADDR, APB_DATA_W'(delay_plan[p]));
            idle_on = idle_plan[p];
            if (p == 4) t_now = 32'hFFFF_FF00;
            run_gestures(3);
            if (p == 2) stall_req = 1'b1;
            if (p == 3) settle();
            run_gestures(2);
        end

        // Label steps up and then down at zero delay, no idling
        program_register(DELAY_ADDR, 32'h0000_0000);
        idle_on = 1'b0;
        repeat (2) begin
            t_now = t_now + 1;
            queue_sample(t_now, 1'b1, 1'b1);
        end
        presses = 5;
        repeat (presses) begin
            for (int s = 0; s < 4; s++) begin
                t_now = t_now + 1;
                queue_sample(t_now, 1'b1 ^ (s < 2), 1'b1);
            end
        end
        repeat (2 * presses) begin
            for (int s = 0; s < 4; s++) begin
                t_now = t_now + 1;
                queue_sample(t_now, 1'b1, 1'b1 ^ (s < 2));
            end
        end

        // Drain and wait out the pipeline
        while (sample_q.size() != 0 || smp.valid) @(negedge i_clk);
        guard = 0;
        while (status_q.size() != 0 && guard < END_GUARD) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (status_q.size() != 0) begin
            report_mismatch("expected results left over", status_q.size(), 0);
        end

        $display("checked %0d results from %0d samples over %0d delay settings", n_checked,
                 n_accepted, n_settings);
        $display("covered chords and row steps, timestamp wrap and step-back, label up and down");
        if (err_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/tbdrc_pkg.sv
design/tbdrc_ifs.sv
design/tbdrc_debounce.sv
design/tbdrc_chord.sv
design/two_button_debounce_row_cycler_core.sv
design/tbdrc_checker.sv
tb/sv/tb_top.sv
